// ===== sv/dobrl_pkg.sv =====
// shared types, constants, microcode table and arithmetic helpers of the disturbance observer
package dobrl_pkg;

   // field widths
   localparam int DATA_W     = 32;
   localparam int DT_W       = 24;
   localparam int COEF_W     = 17;
   localparam int GAIN_W     = 16;
   localparam int MAX_AXES   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // datapath widths
   localparam int OPA_W     = COEF_W + 1;           // unsigned coefficient as signed operand
   localparam int OPB_W     = DATA_W + 1;           // exact rate difference
   localparam int PROD_W    = OPA_W + OPB_W;
   localparam int RND_W     = PROD_W + 1 - 16;      // product rounded back to q16.16
   localparam int DECAY_W   = DATA_W + 1;
   localparam int MAG_W     = 50;                   // magnitude of coefficient times difference
   localparam int DIV_SHIFT = 8;
   localparam int NUM_W     = MAG_W + DIV_SHIFT;    // dividend of the slope divide
   localparam int SLOPE_W   = DATA_W + 3;
   localparam int SUM_W     = 36;
   localparam int STEP_W    = 4;

   localparam logic [COEF_W-1:0] ONE_Q16 = COEF_W'(65536);

   // axis slots
   localparam int AX_ROLL  = 0;
   localparam int AX_PITCH = 1;
   localparam int AX_YAW   = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_COEFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ROLL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PITCH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_YAW    = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_DECAY,
      OP_MUL_SLOPE,
      OP_ABS,
      OP_DIV_START,
      OP_SLOPE,
      OP_DERIV,
      OP_ERR,
      OP_MUL_GAIN,
      OP_INC,
      OP_INTEG,
      OP_RESULT,
      OP_PUBLISH
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_WAIT_REQ,
      COND_WAIT_DIV,
      COND_WAIT_RSP,
      COND_LANDED,
      COND_MORE_AXES,
      COND_ALWAYS
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              req_ready;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   go;
   } dp_ctrl_type;

   typedef struct packed {
      logic div_busy;
      logic landed;
      logic last_axis;
      logic rsp_blocked;
   } dp_stat_type;

   // program steps
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MUL_DECAY = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_SLOPE = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ABS       = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DIV_START = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIV_WAIT  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SLOPE     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DERIV     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_ERR       = 4'd8;
   localparam logic [STEP_W-1:0] STEP_MUL_GAIN  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_INC       = 4'd10;
   localparam logic [STEP_W-1:0] STEP_INTEG     = 4'd11;
   localparam logic [STEP_W-1:0] STEP_RESULT    = 4'd12;
   localparam logic [STEP_W-1:0] STEP_PUBLISH   = 4'd13;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_IDLE, req_ready: 1'b0};
      unique case (step)
         STEP_IDLE:      w = '{OP_LOAD,      COND_WAIT_REQ,  STEP_MUL_DECAY, 1'b1};
         STEP_MUL_DECAY: w = '{OP_MUL_DECAY, COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_MUL_SLOPE: w = '{OP_MUL_SLOPE, COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_ABS:       w = '{OP_ABS,       COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_DIV_START: w = '{OP_DIV_START, COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_DIV_WAIT:  w = '{OP_NONE,      COND_WAIT_DIV,  STEP_SLOPE,     1'b0};
         STEP_SLOPE:     w = '{OP_SLOPE,     COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_DERIV:     w = '{OP_DERIV,     COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_ERR:       w = '{OP_ERR,       COND_LANDED,    STEP_RESULT,    1'b0};
         STEP_MUL_GAIN:  w = '{OP_MUL_GAIN,  COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_INC:       w = '{OP_INC,       COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_INTEG:     w = '{OP_INTEG,     COND_NEXT,      STEP_IDLE,      1'b0};
         STEP_RESULT:    w = '{OP_RESULT,    COND_MORE_AXES, STEP_MUL_DECAY, 1'b0};
         STEP_PUBLISH:   w = '{OP_PUBLISH,   COND_WAIT_RSP,  STEP_IDLE,      1'b0};
         default:        w = '{OP_NONE,      COND_ALWAYS,    STEP_IDLE,      1'b0};
      endcase
      return w;
   endfunction

   // divide by 2^16, round to nearest, ties away from zero
   function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] n);
      logic [PROD_W:0] s;
      s = {n[PROD_W-1], n} + (n[PROD_W-1] ? (PROD_W+1)'(32767) : (PROD_W+1)'(32768));
      return s[PROD_W:16];
   endfunction

   // saturate to 32 bits signed
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
         r = v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== sv/disturbance_observer_rate_loop.sv =====
// top level of the three-axis disturbance observer for the rate loop
//
//   channel   direction  handshake                 contents
//   req_      in         req_valid / req_ready     rates, setpoints, time step, landed flag
//   rsp_      out        rsp_valid / rsp_ready     torques and integrators per axis
//   csr_      in         csr_write_en              coefficient and per-axis gains
//
// the serial slope divide dominates: 2 quotient bits a cycle
// req_ready is high only while the sequencer sits at its idle step; the result register
// lets the next item in while the last result still waits, publish waits for it to drain
// synchronous active-high reset clears the observer state, config and control; no clear pass
module disturbance_observer_rate_loop #(
   parameter int AXES = dobrl_pkg::MAX_AXES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [dobrl_pkg::DATA_W-1:0]  req_rate_roll,
   input  logic signed [dobrl_pkg::DATA_W-1:0]  req_rate_pitch,
   input  logic signed [dobrl_pkg::DATA_W-1:0]  req_rate_yaw,
   input  logic signed [dobrl_pkg::DATA_W-1:0]  req_setpoint_roll,
   input  logic signed [dobrl_pkg::DATA_W-1:0]  req_setpoint_pitch,
   input  logic signed [dobrl_pkg::DATA_W-1:0]  req_setpoint_yaw,
   input  logic [dobrl_pkg::DT_W-1:0]           req_time_step,
   input  logic                                 req_on_ground,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dobrl_pkg::DATA_W-1:0]  rsp_torque_roll,
   output logic signed [dobrl_pkg::DATA_W-1:0]  rsp_torque_pitch,
   output logic signed [dobrl_pkg::DATA_W-1:0]  rsp_torque_yaw,
   output logic signed [dobrl_pkg::DATA_W-1:0]  rsp_integ_roll,
   output logic signed [dobrl_pkg::DATA_W-1:0]  rsp_integ_pitch,
   output logic signed [dobrl_pkg::DATA_W-1:0]  rsp_integ_yaw,
   // config writes
   input  logic                                 csr_write_en,
   input  logic [dobrl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dobrl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dobrl_pkg::*;

   // config registers
   logic [COEF_W-1:0] coeff_ff, coeff_in;
   logic [GAIN_W-1:0] gain_ff [MAX_AXES], gain_in [MAX_AXES];

   logic signed [DATA_W-1:0] rate_vec [MAX_AXES];
   logic signed [DATA_W-1:0] sp_vec [MAX_AXES];
   logic signed [DATA_W-1:0] torque_vec [MAX_AXES];
   logic signed [DATA_W-1:0] integ_vec [MAX_AXES];

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   // register writes, taken at any time; the user keeps them to idle periods
   always_comb begin
      coeff_in = coeff_ff;
      gain_in  = gain_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DERIV_COEFF: coeff_in          = csr_wdata[COEF_W-1:0];
            CSR_GAIN_ROLL:   gain_in[AX_ROLL]  = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_PITCH:  gain_in[AX_PITCH] = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_YAW:    gain_in[AX_YAW]   = csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
         for (int i = 0; i < MAX_AXES; i++) begin
            gain_ff[i] <= '0;
         end
      end else begin
         coeff_ff <= coeff_in;
         gain_ff  <= gain_in;
      end
   end

   // per-axis views of the payload
   assign rate_vec[AX_ROLL]  = req_rate_roll;
   assign rate_vec[AX_PITCH] = req_rate_pitch;
   assign rate_vec[AX_YAW]   = req_rate_yaw;
   assign sp_vec[AX_ROLL]    = req_setpoint_roll;
   assign sp_vec[AX_PITCH]   = req_setpoint_pitch;
   assign sp_vec[AX_YAW]     = req_setpoint_yaw;

   // step counter and control table
   dobrl_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   // arithmetic, observer state and result register
   dobrl_dp #(
      .AXES (AXES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .stat         (stat),
      .coeff        (coeff_ff),
      .gain         (gain_ff),
      .req_rate     (rate_vec),
      .req_setpoint (sp_vec),
      .time_step    (req_time_step),
      .on_ground    (req_on_ground),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .torque       (torque_vec),
      .integ        (integ_vec)
   );

   assign rsp_torque_roll  = torque_vec[AX_ROLL];
   assign rsp_torque_pitch = torque_vec[AX_PITCH];
   assign rsp_torque_yaw   = torque_vec[AX_YAW];
   assign rsp_integ_roll   = integ_vec[AX_ROLL];
   assign rsp_integ_pitch  = integ_vec[AX_PITCH];
   assign rsp_integ_yaw    = integ_vec[AX_YAW];

   // one item at a time: the sequencer leaves idle right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while an item is in progress");

   // a result appears only from the publish step
   a_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.op == OP_PUBLISH && ctrl.go))
      else $error("result valid raised outside the publish step");

   // the divider has always finished by the time a new item can enter
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_LOAD) |-> !stat.div_busy)
      else $error("divider still busy at idle step");

endmodule

// ===== sv/dobrl_div.sv =====
// unsigned iterative divider, two quotient bits per cycle, rounds to nearest at the end
module dobrl_div #(
   parameter int NUM_W = dobrl_pkg::NUM_W,
   parameter int DEN_W = dobrl_pkg::DT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);
   import dobrl_pkg::*;

   localparam int ITER  = NUM_W / 2;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   logic [DEN_W:0]   t1, t2;
   logic [DEN_W-1:0] r1, r2;
   logic             b1, b2;
   logic [DEN_W-1:0] half_up;
   logic             round_up;

   // two restoring steps
   always_comb begin
      t1 = {rem_ff, quo_ff[NUM_W-1]};
      b1 = t1 >= {1'b0, den};
      r1 = b1 ? DEN_W'(t1 - {1'b0, den}) : t1[DEN_W-1:0];
      t2 = {r1, quo_ff[NUM_W-2]};
      b2 = t2 >= {1'b0, den};
      r2 = b2 ? DEN_W'(t2 - {1'b0, den}) : t2[DEN_W-1:0];
      half_up  = den - (den >> 1);
      round_up = rem_ff >= half_up;
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = CNT_W'(ITER);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = r2;
            quo_in = {quo_ff[NUM_W-3:0], b1, b2};
            cnt_in = cnt_ff - CNT_W'(1);
         end else begin
            quo_in  = quo_ff + NUM_W'(round_up);
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== sv/dobrl_seq.sv =====
// microcode sequencer: step counter, control table lookup and conditional jumps
module dobrl_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  dobrl_pkg::dp_stat_type stat,
   output logic                  req_ready,
   output dobrl_pkg::dp_ctrl_type ctrl
);
   import dobrl_pkg::*;

   logic [STEP_W-1:0] pc_ff, pc_in;
   ucode_type         word;
   logic              go;

   assign word = ucode_rom(pc_ff);

   // release of wait steps; no item is taken while in reset
   always_comb begin
      unique case (word.cond)
         COND_WAIT_REQ: go = req_valid && !reset;
         COND_WAIT_DIV: go = !stat.div_busy;
         COND_WAIT_RSP: go = !stat.rsp_blocked;
         default:       go = 1'b1;
      endcase
      req_ready = word.req_ready && !reset;
      ctrl.op   = word.op;
      ctrl.go   = go;
   end

   // next step
   always_comb begin
      unique case (word.cond)
         COND_WAIT_REQ,
         COND_WAIT_DIV,
         COND_WAIT_RSP:  pc_in = go ? word.target : pc_ff;
         COND_LANDED:    pc_in = stat.landed ? word.target : pc_ff + STEP_W'(1);
         COND_MORE_AXES: pc_in = !stat.last_axis ? word.target : pc_ff + STEP_W'(1);
         COND_ALWAYS:    pc_in = word.target;
         default:        pc_in = pc_ff + STEP_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== sv/dobrl_dp.sv =====
// datapath: operand registers, shared multiplier, divider, per-axis state and result registers
module dobrl_dp #(
   parameter int AXES = dobrl_pkg::MAX_AXES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dobrl_pkg::dp_ctrl_type               ctrl,
   output dobrl_pkg::dp_stat_type               stat,
   input  logic [dobrl_pkg::COEF_W-1:0]         coeff,
   input  logic [dobrl_pkg::GAIN_W-1:0]         gain       [dobrl_pkg::MAX_AXES],
   input  logic signed [dobrl_pkg::DATA_W-1:0]  req_rate     [dobrl_pkg::MAX_AXES],
   input  logic signed [dobrl_pkg::DATA_W-1:0]  req_setpoint [dobrl_pkg::MAX_AXES],
   input  logic [dobrl_pkg::DT_W-1:0]           time_step,
   input  logic                                 on_ground,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [dobrl_pkg::DATA_W-1:0]  torque [dobrl_pkg::MAX_AXES],
   output logic signed [dobrl_pkg::DATA_W-1:0]  integ  [dobrl_pkg::MAX_AXES]
);
   import dobrl_pkg::*;

   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

   // item registers
   logic signed [DATA_W-1:0] rate_ff [AXES], rate_in [AXES];
   logic signed [DATA_W-1:0] sp_ff [AXES], sp_in [AXES];
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic                     landed_ff, landed_in;
   logic [AXIS_W-1:0]        axis_ff, axis_in;

   // observer state
   logic signed [DATA_W-1:0] last_rate_ff [AXES], last_rate_in [AXES];
   logic signed [DATA_W-1:0] last_deriv_ff [AXES], last_deriv_in [AXES];
   logic signed [DATA_W-1:0] integ_ff [AXES], integ_in [AXES];

   // working registers
   logic signed [PROD_W-1:0]  mul_ff, mul_in;
   logic signed [OPB_W-1:0]   diff_ff, diff_in;
   logic signed [DECAY_W-1:0] decay_ff, decay_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic signed [DATA_W-1:0]  deriv_ff, deriv_in;
   logic signed [DATA_W-1:0]  err_ff, err_in;
   logic signed [DECAY_W-1:0] inc_ff, inc_in;

   // results
   logic signed [DATA_W-1:0] res_torque_ff [AXES], res_torque_in [AXES];
   logic signed [DATA_W-1:0] res_integ_ff [AXES], res_integ_in [AXES];
   logic signed [DATA_W-1:0] out_torque_ff [AXES], out_torque_in [AXES];
   logic signed [DATA_W-1:0] out_integ_ff [AXES], out_integ_in [AXES];
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [GAIN_W-1:0]        gain_ax [AXES];
   logic [COEF_W-1:0]        c0;
   logic signed [DATA_W-1:0] cur_rate, cur_sp, cur_last_rate, cur_last_deriv, cur_integ;
   logic [GAIN_W-1:0]        cur_gain;
   logic signed [OPA_W-1:0]  opa;
   logic signed [OPB_W-1:0]  opb;
   logic signed [PROD_W-1:0] product;
   logic signed [RND_W-1:0]  rnd_val;
   logic [PROD_W-1:0]        mag_full;
   logic [NUM_W-1:0]         div_quo;
   logic                     div_busy;
   logic                     div_start;
   logic                     quo_big;
   logic [DATA_W+1:0]        smag;
   logic [SLOPE_W-1:0]       slope_pos;

   for (genvar i = 0; i < AXES; i++) begin : g_gain
      assign gain_ax[i] = gain[i];
   end

   assign c0             = (coeff > ONE_Q16) ? ONE_Q16 : coeff;
   assign cur_rate       = rate_ff[axis_ff];
   assign cur_sp         = sp_ff[axis_ff];
   assign cur_last_rate  = last_rate_ff[axis_ff];
   assign cur_last_deriv = last_deriv_ff[axis_ff];
   assign cur_integ      = integ_ff[axis_ff];
   assign cur_gain       = gain_ax[axis_ff];

   // shared multiplier operands
   always_comb begin
      unique case (ctrl.op)
         OP_MUL_DECAY: begin
            opa = OPA_W'(ONE_Q16 - c0);
            opb = OPB_W'(cur_last_deriv);
         end
         OP_MUL_SLOPE: begin
            opa = OPA_W'(c0);
            opb = diff_ff;
         end
         OP_MUL_GAIN: begin
            opa = OPA_W'(cur_gain);
            opb = OPB_W'(err_ff);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign product = opa * opb;
   assign rnd_val = rnd_q16(mul_ff);
   assign mag_full = mul_ff[PROD_W-1] ? -mul_ff : mul_ff;

   // quotients of 2^33 and more saturate the derivative whatever the decay term
   assign quo_big   = |div_quo[NUM_W-1:DATA_W+1];
   assign smag      = quo_big ? {1'b1, {(DATA_W+1){1'b0}}} : {1'b0, div_quo[DATA_W:0]};
   assign slope_pos = {1'b0, smag};

   assign div_start = ctrl.go && (ctrl.op == OP_DIV_START);

   dobrl_div #(
      .NUM_W (NUM_W),
      .DEN_W (DT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({mag_ff, {DIV_SHIFT{1'b0}}}),
      .den   (dt_ff),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   always_comb begin
      rate_in       = rate_ff;
      sp_in         = sp_ff;
      dt_in         = dt_ff;
      landed_in     = landed_ff;
      axis_in       = axis_ff;
      last_rate_in  = last_rate_ff;
      last_deriv_in = last_deriv_ff;
      integ_in      = integ_ff;
      mul_in        = mul_ff;
      diff_in       = diff_ff;
      decay_in      = decay_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      slope_in      = slope_ff;
      deriv_in      = deriv_ff;
      err_in        = err_ff;
      inc_in        = inc_ff;
      res_torque_in = res_torque_ff;
      res_integ_in  = res_integ_ff;
      out_torque_in = out_torque_ff;
      out_integ_in  = out_integ_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctrl.go) begin
         unique case (ctrl.op)
            OP_LOAD: begin
               for (int i = 0; i < AXES; i++) begin
                  rate_in[i] = req_rate[i];
                  sp_in[i]   = req_setpoint[i];
               end
               // zero time step is taken as one
               dt_in     = (time_step == '0) ? DT_W'(1) : time_step;
               landed_in = on_ground;
               axis_in   = '0;
            end
            OP_MUL_DECAY: begin
               mul_in  = product;
               diff_in = OPB_W'(cur_rate) - OPB_W'(cur_last_rate);
            end
            OP_MUL_SLOPE: begin
               decay_in = rnd_val[DECAY_W-1:0];
               mul_in   = product;
            end
            OP_ABS: begin
               mag_in = mag_full[MAG_W-1:0];
               neg_in = mul_ff[PROD_W-1];
            end
            OP_SLOPE: begin
               slope_in = neg_ff ? -slope_pos : slope_pos;
            end
            OP_DERIV: begin
               deriv_in               = sat32(SUM_W'(decay_ff) + SUM_W'(slope_ff));
               last_deriv_in[axis_ff] = sat32(SUM_W'(decay_ff) + SUM_W'(slope_ff));
               last_rate_in[axis_ff]  = cur_rate;
            end
            OP_ERR: begin
               err_in = sat32(SUM_W'(cur_sp) - SUM_W'(deriv_ff));
            end
            OP_MUL_GAIN: begin
               mul_in = product;
            end
            OP_INC: begin
               inc_in = rnd_val[DECAY_W-1:0];
            end
            OP_INTEG: begin
               integ_in[axis_ff] = sat32(SUM_W'(cur_integ) + SUM_W'(inc_ff));
            end
            OP_RESULT: begin
               res_torque_in[axis_ff] = sat32(SUM_W'(err_ff) + SUM_W'(cur_integ));
               res_integ_in[axis_ff]  = cur_integ;
               if (axis_ff != LAST_AXIS) begin
                  axis_in = axis_ff + AXIS_W'(1);
               end
            end
            OP_PUBLISH: begin
               out_torque_in = res_torque_ff;
               out_integ_in  = res_integ_ff;
               rsp_valid_in  = 1'b1;
            end
            OP_NONE, OP_DIV_START: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            last_rate_ff[i]  <= '0;
            last_deriv_ff[i] <= '0;
            integ_ff[i]      <= '0;
         end
      end else begin
         axis_ff       <= axis_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_rate_ff  <= last_rate_in;
         last_deriv_ff <= last_deriv_in;
         integ_ff      <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff       <= rate_in;
      sp_ff         <= sp_in;
      dt_ff         <= dt_in;
      landed_ff     <= landed_in;
      mul_ff        <= mul_in;
      diff_ff       <= diff_in;
      decay_ff      <= decay_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      slope_ff      <= slope_in;
      deriv_ff      <= deriv_in;
      err_ff        <= err_in;
      inc_ff        <= inc_in;
      res_torque_ff <= res_torque_in;
      res_integ_ff  <= res_integ_in;
      out_torque_ff <= out_torque_in;
      out_integ_ff  <= out_integ_in;
   end

   always_comb begin
      stat.div_busy    = div_busy;
      stat.landed      = landed_ff;
      stat.last_axis   = (axis_ff == LAST_AXIS);
      stat.rsp_blocked = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;

   // axes not built report zero
   for (genvar i = 0; i < MAX_AXES; i++) begin : g_out
      if (i < AXES) begin : g_used
         assign torque[i] = out_torque_ff[i];
         assign integ[i]  = out_integ_ff[i];
      end else begin : g_unused
         assign torque[i] = '0;
         assign integ[i]  = '0;
      end
   end

endmodule
